/* rtl/core/ssh_pkg.sv */
`default_nettype none
package ssh_pkg;

	localparam int ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_WINDOW_LENGTH      = 3'd0,
		REG_ERROR_SUM_LIMIT    = 3'd1,
		REG_JUMP_LIMIT         = 3'd2,
		REG_VALID_DISTANCE_MIN = 3'd3,
		REG_GAP_ERROR_LIMIT    = 3'd4
	} ssh_reg_t;

	localparam logic [9:0]  WINDOW_LENGTH_RST      = 10'd500;
	localparam logic [23:0] ERROR_SUM_LIMIT_RST    = 24'd76800;
	localparam logic [15:0] JUMP_LIMIT_RST         = 16'd896;
	localparam logic [15:0] VALID_DISTANCE_MIN_RST = 16'd128;
	localparam logic [14:0] GAP_ERROR_LIMIT_RST    = 15'd26;

	localparam logic [23:0] SUM_MAX = 24'hFFFFFF;

	typedef struct packed {
		logic [9:0]  window_length;
		logic [23:0] error_sum_limit;
		logic [15:0] jump_limit;
		logic [15:0] valid_distance_min;
		logic [14:0] gap_error_limit;
	} ssh_cfg_t;

endpackage
`default_nettype wire

/* rtl/core/ssh_if.sv */
`default_nettype none
interface ssh_sample_if;
	logic               valid;
	logic               ready;
	logic [15:0]        range_distance;
	logic signed [15:0] speed_error;
	logic [3:0]         platoon_position;
	logic signed [15:0] gap_error;

	modport source (
		output valid, range_distance, speed_error, platoon_position, gap_error,
		input  ready
	);
	modport sink (
		input  valid, range_distance, speed_error, platoon_position, gap_error,
		output ready
	);
endinterface

interface ssh_result_if;
	logic valid;
	logic ready;
	logic use_radar;

	modport source (output valid, use_radar, input ready);
	modport sink (input valid, use_radar, output ready);
endinterface
`default_nettype wire

/* rtl/core/sensor_source_health_selector.sv */
// Sensor source health selector.
// sample: one item per control tick (range distance, speed error, platoon
// position, time-gap error), valid/ready handshake.
// result: one item per sample, use_radar (1 radar/lidar, 0 communication).
// Configuration over an APB-style port, registers at byte address 4*i:
// window_length, error_sum_limit, jump_limit, valid_distance_min,
// gap_error_limit. pready is always high; write only while idle.
// A sample passes the input register, then the result register.
// Throughput: one item per cycle while the result is not stalled, set by
// the update of the health state, done once per accepted sample.
// When the result is stalled, the input register holds one more item and
// the sample side keeps ready high until that slot is also taken.
// Reset: radar selected, fault assumed, window and sum cleared, previous
// distance zero, registers at their defaults, no result pending.
`default_nettype none
module sensor_source_health_selector #(
	parameter int MAX_FOLLOWER_POSITION = 5
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	ssh_sample_if.sink                      sample,
	ssh_result_if.source                    result,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [ssh_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic      [31:0]                prdata,
	output logic                            pready
);
	import ssh_pkg::*;

	ssh_cfg_t           cfg;
	logic               valid_s1;
	logic [15:0]        range_distance_s1;
	logic signed [15:0] speed_error_s1;
	logic [3:0]         platoon_position_s1;
	logic signed [15:0] gap_error_s1;
	logic               advance;
	logic               use_radar_n;
	logic               out_valid_q;
	logic               use_radar_q;

	assign advance      = valid_s1 & (~out_valid_q | result.ready);
	assign sample.ready = ~valid_s1 | advance;
	assign result.valid     = out_valid_q;
	assign result.use_radar = use_radar_q;

	ssh_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ssh_eval #(
		.MAX_FOLLOWER_POSITION (MAX_FOLLOWER_POSITION)
	) u_eval (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.step             (advance),
		.range_distance   (range_distance_s1),
		.speed_error      (speed_error_s1),
		.platoon_position (platoon_position_s1),
		.gap_error        (gap_error_s1),
		.use_radar        (use_radar_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			range_distance_s1   <= sample.range_distance;
			speed_error_s1      <= sample.speed_error;
			platoon_position_s1 <= sample.platoon_position;
			gap_error_s1        <= sample.gap_error;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			use_radar_q <= use_radar_n;
	end
endmodule
`default_nettype wire

/* rtl/core/ssh_cfg.sv */
`default_nettype none
module ssh_cfg (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [ssh_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]               pwdata,
	output logic      [31:0]               prdata,
	output logic                           pready,
	output ssh_pkg::ssh_cfg_t              cfg
);
	import ssh_pkg::*;

	ssh_cfg_t cfg_q;
	ssh_reg_t reg_sel;
	logic     wr_en;

	assign reg_sel = ssh_reg_t'(paddr[ADDR_W-1:2]);
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_length      <= WINDOW_LENGTH_RST;
			cfg_q.error_sum_limit    <= ERROR_SUM_LIMIT_RST;
			cfg_q.jump_limit         <= JUMP_LIMIT_RST;
			cfg_q.valid_distance_min <= VALID_DISTANCE_MIN_RST;
			cfg_q.gap_error_limit    <= GAP_ERROR_LIMIT_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_WINDOW_LENGTH:      cfg_q.window_length      <= pwdata[9:0];
				REG_ERROR_SUM_LIMIT:    cfg_q.error_sum_limit    <= pwdata[23:0];
				REG_JUMP_LIMIT:         cfg_q.jump_limit         <= pwdata[15:0];
				REG_VALID_DISTANCE_MIN: cfg_q.valid_distance_min <= pwdata[15:0];
				REG_GAP_ERROR_LIMIT:    cfg_q.gap_error_limit    <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_WINDOW_LENGTH:      prdata = {22'd0, cfg_q.window_length};
			REG_ERROR_SUM_LIMIT:    prdata = {8'd0, cfg_q.error_sum_limit};
			REG_JUMP_LIMIT:         prdata = {16'd0, cfg_q.jump_limit};
			REG_VALID_DISTANCE_MIN: prdata = {16'd0, cfg_q.valid_distance_min};
			REG_GAP_ERROR_LIMIT:    prdata = {17'd0, cfg_q.gap_error_limit};
			default:                prdata = 32'd0;
		endcase
	end
endmodule
`default_nettype wire

/* rtl/core/ssh_eval.sv */
`default_nettype none
module ssh_eval #(
	parameter int MAX_FOLLOWER_POSITION = 5
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ssh_pkg::ssh_cfg_t  cfg,
	input  wire logic               step,
	input  wire logic [15:0]        range_distance,
	input  wire logic signed [15:0] speed_error,
	input  wire logic [3:0]         platoon_position,
	input  wire logic signed [15:0] gap_error,
	output logic                    use_radar
);
	import ssh_pkg::*;

	localparam logic [3:0] MAX_POS = 4'(MAX_FOLLOWER_POSITION);

	logic        source_q, fault_q;
	logic [9:0]  count_q;
	logic [23:0] sum_q;
	logic [15:0] prev_q;

	logic        source_n, fault_n;
	logic [9:0]  count_n, win;
	logic [23:0] sum_n;
	logic [15:0] mag, diff;
	logic [24:0] sum_w;
	logic        follower;

	assign win      = (cfg.window_length == 10'd0) ? 10'd1 : cfg.window_length;
	assign follower = (platoon_position >= 4'd2) && (platoon_position <= MAX_POS);
	assign mag      = speed_error[15] ? (~speed_error + 16'd1) : speed_error;
	assign diff     = (prev_q >= range_distance) ? (prev_q - range_distance)
	                                             : (range_distance - prev_q);

	always_comb begin
		source_n = source_q;
		fault_n  = fault_q;
		count_n  = count_q;
		sum_n    = sum_q;
		sum_w    = 25'd0;

		// window end
		if (count_n >= win) begin
			if (sum_n < cfg.error_sum_limit)
				fault_n = 1'b0;
			sum_n   = 24'd0;
			count_n = 10'd0;
		end

		// accumulate while suspect and a follower
		if (fault_n && follower) begin
			sum_w = {1'b0, sum_n} + {9'd0, mag};
			sum_n = sum_w[24] ? SUM_MAX : sum_w[23:0];
			if (sum_n > cfg.error_sum_limit)
				count_n = win - 10'd1;
			count_n = count_n + 10'd1;
		end

		if (prev_q < cfg.valid_distance_min) begin
			source_n = 1'b1;
			fault_n  = 1'b1;
			count_n  = 10'd0;
		end

		if (prev_q > cfg.valid_distance_min) begin
			if (diff < cfg.jump_limit && !fault_n) begin
				source_n = 1'b0;
				count_n  = 10'd0;
			end
			if (diff > cfg.jump_limit) begin
				source_n = 1'b1;
				fault_n  = 1'b1;
			end
		end

		if (platoon_position <= 4'd1)
			source_n = 1'b1;

		if (gap_error > $signed({1'b0, cfg.gap_error_limit})) begin
			source_n = 1'b1;
			fault_n  = 1'b1;
		end
	end

	assign use_radar = source_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_q <= 1'b1;
			fault_q  <= 1'b1;
			count_q  <= 10'd0;
			sum_q    <= 24'd0;
			prev_q   <= 16'd0;
		end else if (step) begin
			source_q <= source_n;
			fault_q  <= fault_n;
			count_q  <= count_n;
			sum_q    <= sum_n;
			prev_q   <= range_distance;
		end
	end
endmodule
`default_nettype wire

/* rtl/core/ssh_checker.sv */
`default_nettype none
module ssh_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        sample_valid,
	input wire logic        sample_ready,
	input wire logic        result_valid,
	input wire logic        result_ready,
	input wire logic        result_use_radar,
	input wire logic        psel,
	input wire logic        penable,
	input wire logic        pwrite,
	input wire logic [4:0]  paddr,
	input wire logic [31:0] pwdata,
	input wire logic [31:0] prdata
);
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !result_valid)
		else $error("result valid during reset");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_use_radar))
		else $error("stalled result changed");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> sample_ready)
		else $error("sample stalled with empty result stage");

	a_result_from_sample: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(sample_valid && sample_ready, 2))
		else $error("result without a sample two cycles before");

	a_window_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr == 5'd0) ##1 (paddr == 5'd0)
		|-> prdata[9:0] == $past(pwdata[9:0]))
		else $error("window length readback mismatch");
endmodule

bind sensor_source_health_selector ssh_checker u_ssh_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.sample_valid     (sample.valid),
	.sample_ready     (sample.ready),
	.result_valid     (result.valid),
	.result_ready     (result.ready),
	.result_use_radar (result.use_radar),
	.psel             (psel),
	.penable          (penable),
	.pwrite           (pwrite),
	.paddr            (paddr),
	.pwdata           (pwdata),
	.prdata           (prdata)
);
`default_nettype wire
